// ===== rtl/core/wdds_pkg.sv =====
// Shared types, constants and codes of the wavetable DDS DAC driver.
package wdds_pkg;

   localparam int TABLE_SAMPLES_DEFAULT = 256;
   localparam int WAVE_COUNT_DEFAULT    = 4;

   // Phase is held as the sample position in units of 1/PHASE_UNITS sample,
   // divided by TABLE_SAMPLES, which every increment shares.
   localparam int PHASE_UNITS = 10000;
   localparam int PHASE_W     = 14;
   localparam int REM_W       = PHASE_W + 1;

   localparam int PROD_W    = 20;
   localparam int MODQ_W    = 7;
   localparam int MOD_RECIP = (1 << PROD_W) / PHASE_UNITS;

   localparam int QUEUE_DEPTH = 2;

   localparam int ENTRY_FRAC = 14;
   localparam int SUM_W      = 24;
   localparam int CODE_SHIFT = 7;
   localparam int CODE_DIV   = 25;
   localparam int CODE_V_W   = 13;
   localparam int CODE_RECIP = (1 << CODE_V_W) / CODE_DIV;
   localparam int CODE_LIMIT = 256 * (1 << CODE_SHIFT) * CODE_DIV;
   localparam int CODE_REM_W = 6;

   localparam logic [15:0] FRAME_ACTIVE   = 16'h3000;
   localparam logic [15:0] FRAME_SHUTDOWN = 16'h2000;

   localparam int CSR_DATA_W = 10;

   typedef enum logic [1:0] {
      CSR_FREQ   = 2'd0,
      CSR_MAG    = 2'd1,
      CSR_OFFSET = 2'd2,
      CSR_WAVE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_START = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [9:0]         elapsed_ms;
      logic [1:0]         table_wave;
      logic [7:0]         table_index;
      logic signed [15:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic [15:0] spi_word;
      logic [7:0]  dac_code;
   } rsp_item_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [9:0]         elapsed_ms;
      logic [1:0]         table_wave;
      logic [7:0]         table_index;
      logic signed [15:0] table_value;
   } q_entry_type;

   typedef struct packed {
      logic [9:0]        frequency_tenths_hz;
      logic [5:0]        magnitude_tenths_volt;
      logic signed [6:0] offset_tenths_volt;
      logic [1:0]        waveform_select;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frequency_tenths_hz:   10'd10,
      magnitude_tenths_volt: 6'd10,
      offset_tenths_volt:    7'sd0,
      waveform_select:       2'd0
   };

endpackage

// ===== rtl/core/wdds_front.sv =====
// Front end: takes requests, decodes them and drops table writes out of range.
module wdds_front #(
   parameter int TABLE_SAMPLES = wdds_pkg::TABLE_SAMPLES_DEFAULT,
   parameter int WAVE_COUNT    = wdds_pkg::WAVE_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wdds_pkg::req_item_type req_data,
   input  logic                  q_full,
   output logic                  push,
   output wdds_pkg::q_entry_type push_data
);

   logic                  valid_ff;
   wdds_pkg::q_entry_type entry_ff;
   wdds_pkg::q_entry_type entry_in;
   wdds_pkg::cmd_type     cmd;
   logic                  keep;

   assign req_stall = valid_ff && q_full;
   assign push      = valid_ff && !q_full;
   assign push_data = entry_ff;

   always_comb begin
      cmd = wdds_pkg::cmd_type'(req_data.req_type);
      unique case (cmd)
         wdds_pkg::CMD_WRITE: begin
            keep = (int'(req_data.table_wave) < WAVE_COUNT) &&
                   (int'(req_data.table_index) < TABLE_SAMPLES);
         end
         wdds_pkg::CMD_TICK,
         wdds_pkg::CMD_START,
         wdds_pkg::CMD_STOP: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b1;
         end
      endcase
      entry_in.cmd         = cmd;
      entry_in.elapsed_ms  = req_data.elapsed_ms;
      entry_in.table_wave  = req_data.table_wave;
      entry_in.table_index = req_data.table_index;
      entry_in.table_value = req_data.table_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== rtl/core/wdds_queue.sv =====
// Short FIFO of decoded commands between front and back end.
module wdds_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wdds_pkg::q_entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output wdds_pkg::q_entry_type pop_data,
   output logic                  empty
);

   localparam int DEPTH = wdds_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   wdds_pkg::q_entry_type entries_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff;
   logic [PW-1:0]         rd_ptr_ff;
   logic [CW-1:0]         count_ff;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      if (int'(p) == DEPTH - 1) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");

endmodule

// ===== rtl/core/wdds_back.sv =====
// Back end: wavetable memory, phase accumulator, scaling sequencer and output register.
module wdds_back #(
   parameter int TABLE_SAMPLES = wdds_pkg::TABLE_SAMPLES_DEFAULT,
   parameter int WAVE_COUNT    = wdds_pkg::WAVE_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wdds_pkg::cfg_type     cfg,
   input  logic                  q_empty,
   input  wdds_pkg::q_entry_type q_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wdds_pkg::rsp_item_type rsp_data
);

   localparam int AW        = $clog2(WAVE_COUNT * TABLE_SAMPLES);
   localparam int DEPTH     = WAVE_COUNT * TABLE_SAMPLES;
   localparam int SW        = $clog2(TABLE_SAMPLES);
   localparam int WSW       = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;
   localparam int XW        = $clog2(wdds_pkg::PHASE_UNITS * TABLE_SAMPLES);
   localparam int DIV_RECIP = (1 << XW) / wdds_pkg::PHASE_UNITS;
   localparam int PROD_W    = wdds_pkg::PROD_W;
   localparam int REM_W     = wdds_pkg::REM_W;
   localparam int PHASE_W   = wdds_pkg::PHASE_W;
   localparam int SUM_W     = wdds_pkg::SUM_W;
   localparam int CVW       = wdds_pkg::CODE_V_W;
   localparam int MQW       = wdds_pkg::MODQ_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MODQ,
      ST_MODR,
      ST_PHASE,
      ST_SCALE,
      ST_DIVQ,
      ST_DIVR,
      ST_ADDR,
      ST_READ,
      ST_SUM,
      ST_CODEQ,
      ST_CODER,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   wdds_pkg::q_entry_type  cur_ff;
   logic                   running_ff;
   logic [PHASE_W-1:0]     phase_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [MQW-1:0]         q1_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [XW-1:0]          x_ff;
   logic [SW-1:0]          q2_ff;
   logic [SW-1:0]          sample_ff;
   logic [WSW-1:0]         sel_ff;
   logic [AW-1:0]          raddr_ff;
   logic signed [15:0]     rd_data_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [CVW-1:0]         v_ff;
   logic [7:0]             q3_ff;
   logic                   neg_ff;
   logic                   sat_ff;
   logic [7:0]             code_ff;
   logic                   active_ff;
   logic                   rsp_valid_ff;
   wdds_pkg::rsp_item_type rsp_data_ff;

   logic signed [15:0]     wavetable_mem [DEPTH];

   logic                   out_blocked;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [PROD_W-1:0]      tick_prod;
   logic [2*PROD_W-1:0]    modq_full;
   logic [PROD_W-1:0]      modr;
   logic [REM_W-1:0]       rem_fold;
   logic [REM_W-1:0]       phase_sum;
   logic [PHASE_W-1:0]     phase_next;
   logic [2*XW-1:0]        divq_full;
   logic [XW-1:0]          rem2;
   logic [SW-1:0]          sample_next;
   logic signed [SUM_W-1:0] off_term;
   logic signed [SUM_W-1:0] mag_term;
   logic [2*CVW-1:0]       codeq_full;
   logic [CVW-1:0]         rem3;
   logic [7:0]             code_next;

   // waveform_select taken modulo WAVE_COUNT by up to three subtractions
   function automatic logic [WSW-1:0] wrap_wave(input logic [1:0] s);
      logic [2:0] r;
      r = {1'b0, s};
      for (int i = 0; i < 3; i++) begin
         if (int'(r) >= WAVE_COUNT) begin
            r = r - 3'(WAVE_COUNT);
         end
      end
      return WSW'(r);
   endfunction

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign pop         = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign mem_we      = (state_ff == ST_DISPATCH) && (cur_ff.cmd == wdds_pkg::CMD_WRITE);
   assign mem_waddr   = AW'(32'(cur_ff.table_wave) * TABLE_SAMPLES + 32'(cur_ff.table_index));

   always_comb begin
      tick_prod = PROD_W'(cfg.frequency_tenths_hz) * PROD_W'(cur_ff.elapsed_ms);
      modq_full = (2*PROD_W)'(prod_ff) * (2*PROD_W)'(wdds_pkg::MOD_RECIP);
      modr      = prod_ff - PROD_W'(q1_ff) * PROD_W'(wdds_pkg::PHASE_UNITS);

      rem_fold  = (rem_ff >= REM_W'(wdds_pkg::PHASE_UNITS)) ?
                  rem_ff - REM_W'(wdds_pkg::PHASE_UNITS) : rem_ff;
      phase_sum = REM_W'(phase_ff) + rem_fold;
      phase_next = (phase_sum >= REM_W'(wdds_pkg::PHASE_UNITS)) ?
                   PHASE_W'(phase_sum - REM_W'(wdds_pkg::PHASE_UNITS)) :
                   PHASE_W'(phase_sum);

      divq_full   = (2*XW)'(x_ff) * (2*XW)'(DIV_RECIP);
      rem2        = x_ff - XW'(q2_ff) * XW'(wdds_pkg::PHASE_UNITS);
      sample_next = (rem2 >= XW'(wdds_pkg::PHASE_UNITS)) ? q2_ff + SW'(1) : q2_ff;

      off_term = {{(SUM_W-7){cfg.offset_tenths_volt[6]}}, cfg.offset_tenths_volt}
                 <<< wdds_pkg::ENTRY_FRAC;
      mag_term = $signed({{(SUM_W-6){1'b0}}, cfg.magnitude_tenths_volt}) *
                 $signed({{(SUM_W-16){rd_data_ff[15]}}, rd_data_ff});

      codeq_full = (2*CVW)'(sum_ff[wdds_pkg::CODE_SHIFT +: CVW]) *
                   (2*CVW)'(wdds_pkg::CODE_RECIP);
      rem3       = v_ff - CVW'(q3_ff) * CVW'(wdds_pkg::CODE_DIV);
      if (neg_ff) begin
         code_next = 8'd0;
      end else if (sat_ff) begin
         code_next = 8'hFF;
      end else if (rem3 >= CVW'(wdds_pkg::CODE_DIV)) begin
         code_next = q3_ff + 8'd1;
      end else begin
         code_next = q3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the emit step reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  cur_ff   <= q_data;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               unique case (cur_ff.cmd)
                  wdds_pkg::CMD_WRITE: begin
                     state_ff <= ST_IDLE;
                  end
                  wdds_pkg::CMD_START: begin
                     running_ff <= 1'b1;
                     phase_ff   <= '0;
                     state_ff   <= ST_IDLE;
                  end
                  wdds_pkg::CMD_STOP: begin
                     running_ff <= 1'b0;
                     code_ff    <= 8'd0;
                     active_ff  <= 1'b0;
                     state_ff   <= ST_EMIT;
                  end
                  wdds_pkg::CMD_TICK: begin
                     prod_ff  <= tick_prod;
                     sel_ff   <= wrap_wave(cfg.waveform_select);
                     state_ff <= running_ff ? ST_MODQ : ST_IDLE;
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_MODQ: begin
               q1_ff    <= MQW'(modq_full >> PROD_W);
               state_ff <= ST_MODR;
            end
            ST_MODR: begin
               rem_ff   <= REM_W'(modr);
               state_ff <= ST_PHASE;
            end
            ST_PHASE: begin
               phase_ff <= phase_next;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               x_ff     <= XW'(phase_ff) * XW'(TABLE_SAMPLES);
               state_ff <= ST_DIVQ;
            end
            ST_DIVQ: begin
               q2_ff    <= SW'(divq_full >> XW);
               state_ff <= ST_DIVR;
            end
            ST_DIVR: begin
               sample_ff <= sample_next;
               state_ff  <= ST_ADDR;
            end
            ST_ADDR: begin
               raddr_ff <= AW'(32'(sel_ff) * TABLE_SAMPLES + 32'(sample_ff));
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff   <= SUM_W'(off_term + mag_term);
               state_ff <= ST_CODEQ;
            end
            ST_CODEQ: begin
               neg_ff   <= sum_ff[SUM_W-1];
               sat_ff   <= !sum_ff[SUM_W-1] && (sum_ff >= SUM_W'(wdds_pkg::CODE_LIMIT));
               v_ff     <= sum_ff[wdds_pkg::CODE_SHIFT +: CVW];
               q3_ff    <= 8'(codeq_full >> CVW);
               state_ff <= ST_CODER;
            end
            ST_CODER: begin
               code_ff   <= code_next;
               active_ff <= 1'b1;
               state_ff  <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!out_blocked) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.spi_word <= (active_ff ? wdds_pkg::FRAME_ACTIVE :
                                          wdds_pkg::FRAME_SHUTDOWN) | {4'b0, code_ff, 4'b0};
                  rsp_data_ff.dac_code <= code_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // table port: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wavetable_mem[mem_waddr] <= cur_ff.table_value;
      end
      rd_data_ff <= wavetable_mem[raddr_ff];
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      int'(phase_ff) < wdds_pkg::PHASE_UNITS)
      else $error("phase accumulator out of range");
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR) |-> (int'(sample_ff) < TABLE_SAMPLES))
      else $error("sample index beyond table");
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && !out_blocked |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not loaded into output register");

endmodule

// ===== rtl/core/wavetable_dds_dac_driver_top.sv =====
// Top level of the wavetable DDS DAC driver: ports, control registers, front/queue/back.
//
//  channel   direction  handshake              payload
//  req_*     in         req_valid / req_stall  wdds_pkg::req_item_type
//  rsp_*     out        rsp_valid / rsp_stall  wdds_pkg::rsp_item_type
//  csr_*     in         csr_valid / csr_ready  csr_index, csr_data
//
// A tick while running passes through the back-end sequencer from queue pop to result:
// dispatch, its chain of multiply and reciprocal-divide steps, the table read and emit.
// Table writes, starts and idle ticks return to idle after dispatch; a stop goes on to emit.
// The front stage and a 2-entry queue keep taking requests while the back end works, until the queue is full.
// A stalled result holds the output register; the back end waits only in its last step.
// Synchronous reset clears control state; the table contents are undefined until written.
module wavetable_dds_dac_driver_top #(
   parameter int TABLE_SAMPLES = wdds_pkg::TABLE_SAMPLES_DEFAULT,
   parameter int WAVE_COUNT    = wdds_pkg::WAVE_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wdds_pkg::req_item_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wdds_pkg::rsp_item_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [wdds_pkg::CSR_DATA_W-1:0] csr_data
);

   wdds_pkg::cfg_type     cfg_ff;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_empty;
   wdds_pkg::q_entry_type q_in_data;
   wdds_pkg::q_entry_type q_out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wdds_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (wdds_pkg::csr_index_type'(csr_index))
            wdds_pkg::CSR_FREQ:   cfg_ff.frequency_tenths_hz   <= csr_data[9:0];
            wdds_pkg::CSR_MAG:    cfg_ff.magnitude_tenths_volt <= csr_data[5:0];
            wdds_pkg::CSR_OFFSET: cfg_ff.offset_tenths_volt    <= csr_data[6:0];
            wdds_pkg::CSR_WAVE:   cfg_ff.waveform_select       <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   wdds_front #(
      .TABLE_SAMPLES (TABLE_SAMPLES),
      .WAVE_COUNT    (WAVE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (q_push),
      .push_data (q_in_data)
   );

   wdds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   wdds_back #(
      .TABLE_SAMPLES (TABLE_SAMPLES),
      .WAVE_COUNT    (WAVE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
